// ===== rtl/lsfr_pkg.sv =====
`default_nettype none

package lsfr_pkg;

   // table size and field widths
   localparam int TABLE_ENTRIES = 8;
   localparam int ID_WIDTH = 6;
   localparam int ENTRY_WIDTH = 3;
   localparam int COUNT_WIDTH = 4;
   localparam int TABLE_WIDTH = TABLE_ENTRIES * ID_WIDTH;
   localparam int CSR_DATA_WIDTH = 48;
   localparam int CSR_INDEX_WIDTH = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ID_TABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION_MASK = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTRIES_IN_USE = 2'd2;

   // reset value of the entry count
   localparam logic [COUNT_WIDTH-1:0] ENTRIES_RESET = 4'd8;

   // event codes on the result channel
   localparam logic [1:0] EV_TX_REQUEST = 2'd0;
   localparam logic [1:0] EV_RX_MATCH = 2'd1;
   localparam logic [1:0] EV_DATA = 2'd2;

   // protected identifier layout
   localparam logic [7:0] PID_ID_MASK = 8'hFC;
   localparam logic [1:0] LEN_CODE_MASK = 2'h3;

   // response lengths by identifier bits 1..0
   localparam logic [1:0] LEN_CODE_FIVE = 2'd2;
   localparam logic [1:0] LEN_CODE_NINE = 2'd3;
   localparam logic [COUNT_WIDTH-1:0] LEN_SHORT = 4'd3;
   localparam logic [COUNT_WIDTH-1:0] LEN_MID = 4'd5;
   localparam logic [COUNT_WIDTH-1:0] LEN_LONG = 4'd9;

   // receiver phase
   typedef enum logic [3:0] {
      PH_BREAK = 4'b0001,
      PH_SYNC  = 4'b0010,
      PH_PID   = 4'b0100,
      PH_DATA  = 4'b1000
   } phase_type;

   // identifier lookup result
   typedef struct packed {
      logic                   hit;
      logic [ENTRY_WIDTH-1:0] entry;
      logic                   is_rx;
   } match_type;

   // response length from the identifier
   function automatic logic [COUNT_WIDTH-1:0] frame_len(input logic [ID_WIDTH-1:0] id);
      logic [1:0] code;
      logic [COUNT_WIDTH-1:0] len;
      code = id[1:0] & LEN_CODE_MASK;
      case (code)
         LEN_CODE_FIVE: len = LEN_MID;
         LEN_CODE_NINE: len = LEN_LONG;
         default:       len = LEN_SHORT;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lsfr_id_matcher.sv =====
`default_nettype none

module lsfr_id_matcher (
   input  wire logic [lsfr_pkg::TABLE_WIDTH-1:0]   id_table,
   input  wire logic [lsfr_pkg::TABLE_ENTRIES-1:0] direction_mask,
   input  wire logic [lsfr_pkg::COUNT_WIDTH-1:0]   entries_in_use,
   input  wire logic [lsfr_pkg::ID_WIDTH-1:0]      id,
   output lsfr_pkg::match_type                     match
);

   logic [lsfr_pkg::COUNT_WIDTH-1:0] limit;

   // entries beyond the table size are never compared
   always_comb begin
      if (entries_in_use > lsfr_pkg::COUNT_WIDTH'(lsfr_pkg::TABLE_ENTRIES)) begin
         limit = lsfr_pkg::COUNT_WIDTH'(lsfr_pkg::TABLE_ENTRIES);
      end else begin
         limit = entries_in_use;
      end
   end

   // parallel compare, lowest matching entry wins
   always_comb begin
      match = '0;
      for (int k = lsfr_pkg::TABLE_ENTRIES - 1; k >= 0; k--) begin
         if ((lsfr_pkg::COUNT_WIDTH'(k) < limit) &&
             (id_table[k*lsfr_pkg::ID_WIDTH +: lsfr_pkg::ID_WIDTH] == id)) begin
            match.hit = 1'b1;
            match.entry = lsfr_pkg::ENTRY_WIDTH'(k);
            match.is_rx = direction_mask[k];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lin_slave_frame_receiver_unit.sv =====
// path: an accepted byte is held in the input register and then moves on to
// the result register, which offers its result on the response channel
// throughput: one byte per cycle unless the output stalls; the phase update and
// table compare sit in one stage between the input and result registers
// reset: synchronous, active high; clears phase, counters, valid flags and the
// configuration registers (id table 0, direction mask 0, entries in use 8)
`default_nettype none

module lin_slave_frame_receiver_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_rx_byte,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_event_kind,
   output logic [lsfr_pkg::ID_WIDTH-1:0]             rsp_frame_id,
   output logic [lsfr_pkg::ENTRY_WIDTH-1:0]          rsp_entry_index,
   output logic [7:0]                                rsp_data_byte,
   output logic [lsfr_pkg::COUNT_WIDTH-1:0]          rsp_byte_index,
   output logic                                      rsp_last,
   // configuration
   input  wire logic                                 csr_write_enable,
   input  wire logic [lsfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [lsfr_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // configuration registers
   logic [lsfr_pkg::TABLE_WIDTH-1:0]   id_table_ff;
   logic [lsfr_pkg::TABLE_ENTRIES-1:0] direction_mask_ff;
   logic [lsfr_pkg::COUNT_WIDTH-1:0]   entries_in_use_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // frame state
   lsfr_pkg::phase_type              phase_ff, phase_in;
   logic [lsfr_pkg::COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [lsfr_pkg::COUNT_WIDTH-1:0] frame_length_ff, frame_length_in;
   logic [lsfr_pkg::ID_WIDTH-1:0]    current_id_ff, current_id_in;
   logic [lsfr_pkg::ENTRY_WIDTH-1:0] current_entry_ff, current_entry_in;

   // result register
   logic                             out_valid_ff, out_valid_in;
   logic [1:0]                       out_kind_ff, out_kind_in;
   logic [lsfr_pkg::ID_WIDTH-1:0]    out_id_ff, out_id_in;
   logic [lsfr_pkg::ENTRY_WIDTH-1:0] out_entry_ff, out_entry_in;
   logic [7:0]                       out_data_ff, out_data_in;
   logic [lsfr_pkg::COUNT_WIDTH-1:0] out_index_ff, out_index_in;
   logic                             out_last_ff, out_last_in;

   logic                             out_free;
   logic                             process;
   logic                             emit;
   logic [lsfr_pkg::ID_WIDTH-1:0]    pid_id;
   logic [7:0]                       pid_masked;
   logic [lsfr_pkg::COUNT_WIDTH-1:0] next_count;
   logic                             final_byte;
   lsfr_pkg::match_type              match;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         id_table_ff <= '0;
         direction_mask_ff <= '0;
         entries_in_use_ff <= lsfr_pkg::ENTRIES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            lsfr_pkg::CSR_ID_TABLE: begin
               id_table_ff <= csr_write_data[lsfr_pkg::TABLE_WIDTH-1:0];
            end
            lsfr_pkg::CSR_DIRECTION_MASK: begin
               direction_mask_ff <= csr_write_data[lsfr_pkg::TABLE_ENTRIES-1:0];
            end
            lsfr_pkg::CSR_ENTRIES_IN_USE: begin
               entries_in_use_ff <= csr_write_data[lsfr_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake: the held byte moves on whenever the result register can take it
   assign out_free = !out_valid_ff || !rsp_stall;
   assign process = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // identifier lookup
   assign pid_masked = in_byte_ff & lsfr_pkg::PID_ID_MASK;
   assign pid_id = pid_masked[7:2];

   lsfr_id_matcher u_matcher (
      .id_table       (id_table_ff),
      .direction_mask (direction_mask_ff),
      .entries_in_use (entries_in_use_ff),
      .id             (pid_id),
      .match          (match)
   );

   // data byte position
   assign next_count = byte_count_ff + 4'd1;
   assign final_byte = next_count >= frame_length_ff;

   // frame phase and result
   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      frame_length_in = frame_length_ff;
      current_id_in = current_id_ff;
      current_entry_in = current_entry_ff;
      emit = 1'b0;
      out_kind_in = lsfr_pkg::EV_TX_REQUEST;
      out_id_in = current_id_ff;
      out_entry_in = current_entry_ff;
      out_data_in = '0;
      out_index_in = '0;
      out_last_in = 1'b0;
      case (phase_ff)
         lsfr_pkg::PH_BREAK: begin
            if (in_byte_ff == 8'd0) begin
               phase_in = lsfr_pkg::PH_SYNC;
            end
         end
         lsfr_pkg::PH_SYNC: begin
            phase_in = lsfr_pkg::PH_PID;
         end
         lsfr_pkg::PH_PID: begin
            phase_in = lsfr_pkg::PH_BREAK;
            if (match.hit) begin
               current_id_in = pid_id;
               current_entry_in = match.entry;
               frame_length_in = lsfr_pkg::frame_len(pid_id);
               byte_count_in = '0;
               emit = 1'b1;
               out_id_in = pid_id;
               out_entry_in = match.entry;
               if (match.is_rx) begin
                  phase_in = lsfr_pkg::PH_DATA;
                  out_kind_in = lsfr_pkg::EV_RX_MATCH;
               end else begin
                  out_kind_in = lsfr_pkg::EV_TX_REQUEST;
               end
            end
         end
         lsfr_pkg::PH_DATA: begin
            emit = 1'b1;
            out_kind_in = lsfr_pkg::EV_DATA;
            out_data_in = in_byte_ff;
            out_index_in = byte_count_ff;
            out_last_in = final_byte;
            if (final_byte) begin
               phase_in = lsfr_pkg::PH_BREAK;
               byte_count_in = '0;
            end else begin
               byte_count_in = next_count;
            end
         end
         default: begin
            phase_in = lsfr_pkg::PH_BREAK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lsfr_pkg::PH_BREAK;
         byte_count_ff <= '0;
         frame_length_ff <= '0;
         current_id_ff <= '0;
         current_entry_ff <= '0;
      end else if (process) begin
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         frame_length_ff <= frame_length_in;
         current_id_ff <= current_id_in;
         current_entry_ff <= current_entry_in;
      end
   end

   // result register
   always_comb begin
      if (process) begin
         out_valid_in = emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && emit) begin
         out_kind_ff <= out_kind_in;
         out_id_ff <= out_id_in;
         out_entry_ff <= out_entry_in;
         out_data_ff <= out_data_in;
         out_index_ff <= out_index_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_frame_id = out_id_ff;
   assign rsp_entry_index = out_entry_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_byte_index = out_index_ff;
   assign rsp_last = out_last_ff;

   // checks
   a_last_only_on_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_event_kind == lsfr_pkg::EV_DATA)
      else $error("last flag on a non-data transaction");

   a_data_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == lsfr_pkg::EV_DATA |-> rsp_byte_index < 4'd9)
      else $error("data byte index beyond longest response");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");

   a_data_length_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lsfr_pkg::PH_DATA |->
         (frame_length_ff == lsfr_pkg::LEN_SHORT || frame_length_ff == lsfr_pkg::LEN_MID ||
          frame_length_ff == lsfr_pkg::LEN_LONG))
      else $error("illegal response length during data phase");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      process && phase_ff == lsfr_pkg::PH_DATA && final_byte |=>
         phase_ff == lsfr_pkg::PH_BREAK)
      else $error("frame did not end after last data byte");

endmodule

`default_nettype wire
